// ===== src/fcsg_pkg.sv =====
// Shared constants, types and control structs of the filled circle span generator.
`timescale 1ns / 1ps

package fcsg_pkg;

    // Input field widths.
    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 6;

    // Every span coordinate leaves the block as a 14 bit two's complement value.
    localparam int OUT_BITS = 14;

    // Offsets and the decision term of the circle loop.
    localparam int X_BITS     = RADIUS_BITS + 1;
    localparam int Y_BITS     = RADIUS_BITS + 2;
    localparam int ARITH_BITS = RADIUS_BITS + 4;

    // Bound on span groups per circle and the counter that enforces it.
    localparam int MAX_GROUPS = 64;
    localparam int CNT_BITS   = $clog2(MAX_GROUPS);

    // Packed beat widths.
    localparam int IN_DATA_BITS  = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((8 * OUT_BITS + 7) / 8) * 8;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } fcsg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new circle and start the loop
        logic step;   // current span group taken, advance one iteration
    } fcsg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;   // the span group on display is the final one
    } fcsg_status_t;

endpackage

// ===== src/filled_circle_span_generator.sv =====
// Top level of the filled circle span generator: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Channel | Direction | tdata fields (low bit up)                       | tuser | tlast
// s_axis  | in        | center_x[11:0], center_y[23:12], radius[29:24]   | -     | -
// m_axis  | out       | eight 14 bit span coordinates, see port comment  | -     | last_of_circle
//
// A circle beat is taken only while the block is idle. In the cycle after it, the first span
// group is on m_axis, and each following cycle with m_axis_tready high moves one
// Andres iteration forward, so a circle of radius r yields about 0.71*r + 1 output
// beats; the single iteration register set sets this pace.
// A stall on m_axis freezes the iteration state, so the beat on display holds.
// rst_n clears the controller to idle and the circle registers to zero.
module filled_circle_span_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // center_x [11:0], center_y [23:12], radius [29:24], zero [31:30]
    input  logic [fcsg_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // wide_left [13:0], wide_right [27:14], wide_row_below [41:28],
    // wide_row_above [55:42], narrow_left [69:56], narrow_right [83:70],
    // narrow_row_below [97:84], narrow_row_above [111:98]
    output logic [fcsg_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import fcsg_pkg::*;

    fcsg_cmd_t    cmd;
    fcsg_status_t status;

    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;

    logic signed [OUT_BITS-1:0] wide_left;
    logic signed [OUT_BITS-1:0] wide_right;
    logic signed [OUT_BITS-1:0] wide_row_below;
    logic signed [OUT_BITS-1:0] wide_row_above;
    logic signed [OUT_BITS-1:0] narrow_left;
    logic signed [OUT_BITS-1:0] narrow_right;
    logic signed [OUT_BITS-1:0] narrow_row_below;
    logic signed [OUT_BITS-1:0] narrow_row_above;

    // Unpack the input beat; the fields sit back to back from bit zero.
    assign center_x = s_axis_tdata[COORD_BITS-1:0];
    assign center_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign radius   = s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];

    fcsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    fcsg_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .center_x         (center_x),
        .center_y         (center_y),
        .radius           (radius),
        .wide_left        (wide_left),
        .wide_right       (wide_right),
        .wide_row_below   (wide_row_below),
        .wide_row_above   (wide_row_above),
        .narrow_left      (narrow_left),
        .narrow_right     (narrow_right),
        .narrow_row_below (narrow_row_below),
        .narrow_row_above (narrow_row_above)
    );

    // The span fields fill the output beat exactly, so no padding is needed.
    assign m_axis_tdata = {narrow_row_above, narrow_row_below, narrow_right, narrow_left,
                           wide_row_above, wide_row_below, wide_right, wide_left};
    assign m_axis_tlast = status.last;

endmodule

// ===== src/fcsg_datapath.sv =====
// Datapath: circle registers, one Andres iteration per step and span arithmetic.
`timescale 1ns / 1ps

module fcsg_datapath (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  fcsg_pkg::fcsg_cmd_t                        cmd,
    output fcsg_pkg::fcsg_status_t                     status,
    input  logic [fcsg_pkg::COORD_BITS-1:0]            center_x,
    input  logic [fcsg_pkg::COORD_BITS-1:0]            center_y,
    input  logic [fcsg_pkg::RADIUS_BITS-1:0]           radius,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]       wide_left,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]       wide_right,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]       wide_row_below,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]       wide_row_above,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]       narrow_left,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]       narrow_right,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]       narrow_row_below,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]       narrow_row_above
);
    import fcsg_pkg::*;

    logic        [COORD_BITS-1:0]  cx_reg;
    logic        [COORD_BITS-1:0]  cy_reg;
    logic        [RADIUS_BITS-1:0] r_reg;
    logic        [X_BITS-1:0]      x_reg;
    logic signed [Y_BITS-1:0]      y_reg;
    logic signed [ARITH_BITS-1:0]  d_reg;
    logic        [CNT_BITS-1:0]    cnt_reg;

    logic signed [ARITH_BITS-1:0]  x_s;
    logic signed [ARITH_BITS-1:0]  y_s;
    logic signed [ARITH_BITS-1:0]  r_s;
    logic signed [ARITH_BITS-1:0]  r_in_s;
    logic signed [ARITH_BITS-1:0]  x_next;
    logic signed [ARITH_BITS-1:0]  y_next;
    logic signed [ARITH_BITS-1:0]  d_next;

    logic signed [OUT_BITS-1:0]    cx_o;
    logic signed [OUT_BITS-1:0]    cy_o;
    logic signed [OUT_BITS-1:0]    x_o;
    logic signed [OUT_BITS-1:0]    y_o;

    assign x_s    = signed'(ARITH_BITS'(x_reg));
    assign y_s    = ARITH_BITS'(y_reg);
    assign r_s    = signed'(ARITH_BITS'(r_reg));
    assign r_in_s = signed'(ARITH_BITS'(radius));

    // One iteration of the Andres decision rule.
    always_comb
    begin
        priority if (d_reg >= (x_s <<< 1))
        begin
            d_next = d_reg - (x_s <<< 1) - ARITH_BITS'(1);
            x_next = x_s + ARITH_BITS'(1);
            y_next = y_s;
        end
        else if (d_reg < ((r_s - y_s) <<< 1))
        begin
            d_next = d_reg + (y_s <<< 1) - ARITH_BITS'(1);
            x_next = x_s;
            y_next = y_s - ARITH_BITS'(1);
        end
        else
        begin
            d_next = d_reg + ((y_s - x_s - ARITH_BITS'(1)) <<< 1);
            x_next = x_s + ARITH_BITS'(1);
            y_next = y_s - ARITH_BITS'(1);
        end
    end

    // The group on display is final when the loop would stop after it.
    assign status.last = (y_next < x_next) || (cnt_reg == CNT_BITS'(MAX_GROUPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            r_reg   <= '0;
            x_reg   <= '0;
            y_reg   <= '0;
            d_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            r_reg   <= radius;
            x_reg   <= '0;
            y_reg   <= signed'(Y_BITS'(radius));
            d_reg   <= r_in_s - ARITH_BITS'(1);
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            x_reg   <= X_BITS'(x_next);
            y_reg   <= Y_BITS'(y_next);
            d_reg   <= d_next;
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end
    end

    assign cx_o = signed'(OUT_BITS'(cx_reg));
    assign cy_o = signed'(OUT_BITS'(cy_reg));
    assign x_o  = signed'(OUT_BITS'(x_reg));
    assign y_o  = OUT_BITS'(y_reg);

    assign wide_left        = cx_o - y_o;
    assign wide_right       = cx_o + y_o;
    assign wide_row_below   = cy_o + x_o;
    assign wide_row_above   = cy_o - x_o;
    assign narrow_left      = cx_o - x_o;
    assign narrow_right     = cx_o + x_o;
    assign narrow_row_below = cy_o + y_o;
    assign narrow_row_above = cy_o - y_o;

endmodule

// ===== src/fcsg_ctrl.sv =====
// Controller: idle/emit state machine that sequences loads and iteration steps.
`timescale 1ns / 1ps

module fcsg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fcsg_pkg::fcsg_cmd_t    cmd,
    input  fcsg_pkg::fcsg_status_t status
);
    import fcsg_pkg::*;

    fcsg_state_t state_reg;
    fcsg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.load = in_valid && in_ready;
        cmd.step = out_valid && out_ready;
    end

`ifndef SYNTHESIS
    a_load_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_EMIT))
        else $error("load did not start span emission");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.last) |=> (state_reg == ST_IDLE))
        else $error("final span group taken but controller still busy");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status.last)))
        else $error("span group changed while stalled");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.step))
        else $error("load and step issued together");
`endif

endmodule

// ===== dv/tb_filled_circle_span_generator.sv =====
// Self-checking testbench for the filled circle span generator: directed circles, then random ones.
`timescale 1ns / 1ps

module tb_filled_circle_span_generator;

    import fcsg_pkg::*;

    // One expected span group. coord[0] is wide_left, in the same order as the
    // output beat, so coord lines up bit for bit with m_axis_tdata.
    typedef struct packed {
        logic                             last;
        logic [7:0][OUT_BITS-1:0]         coord;
    } span_group_t;

    // One row of the directed table. A row marked point is a zero-radius circle,
    // whose single span group is the center itself and is typed in directly.
    typedef struct packed {
        logic [COORD_BITS-1:0]  cx;
        logic [COORD_BITS-1:0]  cy;
        logic [RADIUS_BITS-1:0] r;
        logic                   point;
    } circle_row_t;

    localparam int N_DIRECTED = 14;
    localparam int N_RANDOM   = 196;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      m_axis_tlast;

    span_group_t pending_spans [$];
    int          mismatch_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    filled_circle_span_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver stalls at random with the probability of the current phase.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic string field_name(input int idx);
        case (idx)
            0:       return "wide_left";
            1:       return "wide_right";
            2:       return "wide_row_below";
            3:       return "wide_row_above";
            4:       return "narrow_left";
            5:       return "narrow_right";
            6:       return "narrow_row_below";
            default: return "narrow_row_above";
        endcase
    endfunction

    // Runs the Andres loop for one circle and queues every span group it yields.
    // The decision term moves x, y or both; spans are mirrored about the center.
    task automatic rasterize_circle(input logic [COORD_BITS-1:0] cx_in,
                                    input logic [COORD_BITS-1:0] cy_in,
                                    input logic [RADIUS_BITS-1:0] r_in);
        int          cx;
        int          cy;
        int          r;
        int          sx;
        int          sy;
        int          dec;
        int          groups;
        span_group_t grp;
        cx = int'(cx_in);
        cy = int'(cy_in);
        r = int'(r_in);
        sx = 0;
        sy = r;
        dec = r - 1;
        groups = 0;
        while (sy >= sx && groups < MAX_GROUPS)
        begin
            grp.coord[0] = OUT_BITS'(cx - sy);
            grp.coord[1] = OUT_BITS'(cx + sy);
            grp.coord[2] = OUT_BITS'(cy + sx);
            grp.coord[3] = OUT_BITS'(cy - sx);
            grp.coord[4] = OUT_BITS'(cx - sx);
            grp.coord[5] = OUT_BITS'(cx + sx);
            grp.coord[6] = OUT_BITS'(cy + sy);
            grp.coord[7] = OUT_BITS'(cy - sy);
            groups++;
            if (dec >= 2 * sx)
            begin
                dec = dec - (2 * sx + 1);
                sx = sx + 1;
            end
            else if (dec < 2 * (r - sy))
            begin
                dec = dec + 2 * sy - 1;
                sy = sy - 1;
            end
            else
            begin
                dec = dec + 2 * (sy - sx - 1);
                sy = sy - 1;
                sx = sx + 1;
            end
            // The group just built is the last one once the loop would stop.
            grp.last = !(sy >= sx && groups < MAX_GROUPS);
            pending_spans.push_back(grp);
        end
    endtask

    // Offers one circle beat after a random idle gap and waits for the handshake.
    // Expectations are queued at the accepting edge.
    task automatic send_circle(input logic [COORD_BITS-1:0] cx,
                               input logic [COORD_BITS-1:0] cy,
                               input logic [RADIUS_BITS-1:0] r,
                               input logic point);
        span_group_t grp;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_BITS - 2 * COORD_BITS - RADIUS_BITS){1'b0}}, r, cy, cx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (point)
        begin
            grp.last  = 1'b1;
            grp.coord = {{2'b00, cy}, {2'b00, cy}, {2'b00, cx}, {2'b00, cx},
                         {2'b00, cy}, {2'b00, cy}, {2'b00, cx}, {2'b00, cx}};
            pending_spans.push_back(grp);
        end
        else
            rasterize_circle(cx, cy, r);
        @(negedge clk);
    endtask

    // Output checker: every accepted beat is compared with the oldest expectation.
    always @(posedge clk)
    begin
        span_group_t want;
        span_group_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.coord = m_axis_tdata[8 * OUT_BITS - 1:0];
            got.last  = m_axis_tlast;
            if (pending_spans.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected beat: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = pending_spans.pop_front();
                for (int i = 0; i < 8; i++)
                begin
                    if (got.coord[i] !== want.coord[i])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%s: expected %0d, got %0d", field_name(i),
                                     $signed(want.coord[i]), $signed(got.coord[i]));
                    end
                end
                if (got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("last_of_circle: expected %b, got %b", want.last, got.last);
                end
            end
        end
    end

    initial
    begin
        circle_row_t directed [N_DIRECTED];
        logic [COORD_BITS-1:0]  cx;
        logic [COORD_BITS-1:0]  cy;
        logic [RADIUS_BITS-1:0] r;
        int phase;
        int drain;

        // Zero radius at both coordinate extremes, the largest radius at both
        // corners so spans go negative and past the coordinate range, and a
        // spread of other radii with alternating bit patterns.
        directed[0]  = '{cx: 12'd0,    cy: 12'd0,    r: 6'd0,  point: 1'b1};
        directed[1]  = '{cx: 12'd4095, cy: 12'd4095, r: 6'd0,  point: 1'b1};
        directed[2]  = '{cx: 12'hAAA,  cy: 12'h555,  r: 6'd0,  point: 1'b1};
        directed[3]  = '{cx: 12'd0,    cy: 12'd0,    r: 6'd63, point: 1'b0};
        directed[4]  = '{cx: 12'd4095, cy: 12'd4095, r: 6'd63, point: 1'b0};
        directed[5]  = '{cx: 12'd0,    cy: 12'd4095, r: 6'd1,  point: 1'b0};
        directed[6]  = '{cx: 12'd4095, cy: 12'd0,    r: 6'd2,  point: 1'b0};
        directed[7]  = '{cx: 12'h555,  cy: 12'hAAA,  r: 6'd3,  point: 1'b0};
        directed[8]  = '{cx: 12'd100,  cy: 12'd200,  r: 6'd4,  point: 1'b0};
        directed[9]  = '{cx: 12'd2048, cy: 12'd2047, r: 6'd5,  point: 1'b0};
        directed[10] = '{cx: 12'd1,    cy: 12'd1,    r: 6'h2A, point: 1'b0};
        directed[11] = '{cx: 12'd4094, cy: 12'd3,    r: 6'h15, point: 1'b0};
        directed[12] = '{cx: 12'd31,   cy: 12'd4064, r: 6'd32, point: 1'b0};
        directed[13] = '{cx: 12'd777,  cy: 12'd1234, r: 6'd10, point: 1'b0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part runs without idling on either side.
        for (int i = 0; i < N_DIRECTED; i++)
            send_circle(directed[i].cx, directed[i].cy, directed[i].r, directed[i].point);

        // Hold the sender back until every span group of the table has drained.
        s_axis_tvalid <= 1'b0;
        while (pending_spans.size() != 0)
            @(negedge clk);

        // Random part in four phases: no idling, idle sender, stalling receiver,
        // and both sides idling.
        for (int k = 0; k < N_RANDOM; k++)
        begin
            phase = (k * 4) / N_RANDOM;
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 79; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            cx = COORD_BITS'($urandom_range(4095));
            cy = COORD_BITS'($urandom_range(4095));
            // Every so often pin the center near a border so spans wrap past it.
            if ($urandom_range(7) == 0)
                cx = $urandom_range(1) ? COORD_BITS'($urandom_range(63))
                                       : COORD_BITS'(4095 - $urandom_range(63));
            if ($urandom_range(7) == 0)
                cy = $urandom_range(1) ? COORD_BITS'($urandom_range(63))
                                       : COORD_BITS'(4095 - $urandom_range(63));
            r = $urandom_range(2) == 0 ? RADIUS_BITS'($urandom_range(7))
                                       : RADIUS_BITS'($urandom_range(63));
            send_circle(cx, cy, r, 1'b0);
        end
        s_axis_tvalid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;

        drain = 0;
        while (pending_spans.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);

        if (pending_spans.size() != 0)
            mismatch_count += pending_spans.size();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
